### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the connection limiter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define PSCL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset cycles included.
`define PSCL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/pscl_pkg.sv
// ---------------------------------------------------------------------------
// pscl_pkg
// Types and constants shared by the connection limiter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pscl_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [COUNT_W-1:0] MAX_RESET = 16'd16;

  // Register index as decoded from the word address bit of paddr.
  localparam logic REG_MAX_PER_SOURCE = 1'b0;

  typedef enum logic {
    OP_OPEN  = 1'b0,
    OP_CLOSE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    logic               vld;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count_after;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/pscl_table.sv
// ---------------------------------------------------------------------------
// pscl_table
// Set memory: one row per set, one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module pscl_table #(
  parameter int unsigned SETS  = 256,
  parameter int unsigned ROW_W = 196,
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [SET_W-1:0] waddr,
  input  logic [ROW_W-1:0] wdata,
  input  logic             re,
  input  logic [SET_W-1:0] raddr,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pscl_setidx.sv
// ---------------------------------------------------------------------------
// pscl_setidx
// Set index: source address modulo the set count, a mask or a registered
// reciprocal-multiplication remainder unit depending on the set count.
// ---------------------------------------------------------------------------
`default_nettype none

module pscl_setidx import pscl_pkg::*; #(
  parameter int unsigned SETS = 256,
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] addr,
  output logic              idx_valid,
  output logic [SET_W-1:0]  idx
);

  localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      assign idx_valid = start;
      assign idx       = SET_W'(addr & ADDR_W'(SETS - 1));
    end else begin : g_recip
      // The quotient comes from a multiply by a fixed reciprocal and a
      // correction step; the remainder is the address less quotient times
      // the set count. One register stage after each of the first two steps.
      localparam int unsigned SH = $clog2(SETS);
      localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << ADDR_W) * ((64'd1 << SH) - 64'(SETS))) / 64'(SETS) + 64'd1;
      localparam logic [ADDR_W-1:0] RECIP = RECIP_WIDE[ADDR_W-1:0];

      logic                  v1;
      logic                  v2;
      logic [ADDR_W-1:0]     n_q;
      logic [ADDR_W-1:0]     t1;
      logic [ADDR_W-1:0]     q_q;
      logic [2*ADDR_W-1:0]   prod;

      assign prod = (2*ADDR_W)'(addr) * (2*ADDR_W)'(RECIP);

      always_ff @(posedge clk) begin
        if (rst) begin
          v1 <= 1'b0;
          v2 <= 1'b0;
        end else begin
          v1 <= start;
          v2 <= v1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          n_q <= addr;
          t1  <= prod[2*ADDR_W-1:ADDR_W];
        end
        if (v1) begin
          q_q <= (t1 + ((n_q - t1) >> 1)) >> (SH - 1);
        end
      end

      assign idx_valid = v2;
      assign idx       = SET_W'(n_q - q_q * ADDR_W'(SETS));
    end
  endgenerate

endmodule

`default_nettype wire

### rtl/core/pscl_update.sv
// ---------------------------------------------------------------------------
// pscl_update
// Way match, free-way search and count update for one set row.
// ---------------------------------------------------------------------------
`default_nettype none

module pscl_update import pscl_pkg::*; #(
  parameter int unsigned WAYS = 4
) (
  input  opcode_t             opcode,
  input  logic [ADDR_W-1:0]   source_addr,
  input  logic [COUNT_W-1:0]  max_per_source,
  input  entry_t [WAYS-1:0]   row,
  output entry_t [WAYS-1:0]   row_next,
  output result_t             result
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               free;
  logic [WAY_W-1:0]   free_way;
  entry_t             hit_e;
  logic [COUNT_W:0]   inc;

  // Scanning downward leaves the lowest matching and lowest free way.
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w].vld) begin
        if (row[w].addr == source_addr) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  assign hit_e = row[hit_way];
  assign inc   = {1'b0, hit_e.count} + (COUNT_W+1)'(1);

  always_comb begin
    row_next           = row;
    result.status      = ST_OK;
    result.count_after = '0;
    unique case (opcode)
      OP_OPEN: begin
        if (hit) begin
          if (inc > {1'b0, max_per_source}) begin
            result.status      = ST_LIMIT;
            result.count_after = hit_e.count;
          end else begin
            row_next[hit_way].count = inc[COUNT_W-1:0];
            result.count_after      = inc[COUNT_W-1:0];
          end
        end else if (free) begin
          row_next[free_way].vld   = 1'b1;
          row_next[free_way].addr  = source_addr;
          row_next[free_way].count = COUNT_W'(1);
          result.count_after       = COUNT_W'(1);
        end else begin
          result.status = ST_NO_FREE;
        end
      end
      OP_CLOSE: begin
        if (hit) begin
          if (hit_e.count <= COUNT_W'(1)) begin
            row_next[hit_way].vld   = 1'b0;
            row_next[hit_way].count = '0;
          end else begin
            row_next[hit_way].count = hit_e.count - COUNT_W'(1);
            result.count_after      = hit_e.count - COUNT_W'(1);
          end
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/pscl_regs.sv
// ---------------------------------------------------------------------------
// pscl_regs
// APB register bank holding the per-source connection maximum.
// ---------------------------------------------------------------------------
`default_nettype none

module pscl_regs import pscl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output logic [COUNT_W-1:0] max_per_source
);

  logic reg_idx;

  // Registers are word spaced; the word bit selects the register.
  assign reg_idx = paddr[PADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_per_source <= MAX_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_MAX_PER_SOURCE)) begin
      max_per_source <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MAX_PER_SOURCE: prdata = DATA_W'(max_per_source);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/per_source_connection_limiter.sv
// ---------------------------------------------------------------------------
// per_source_connection_limiter: open-connection counts per source address.
// Path: an accepted item passes the row read register, then the update and the output
// register; for a set count that is not a power of two, the registered set-index division comes first.
// Flow: one item at a time, one set row read and written; the next item is taken only after
// the lookup is done. Reset: synchronous; a clearing pass then zeroes every row.
// ---------------------------------------------------------------------------
`default_nettype none

module per_source_connection_limiter import pscl_pkg::*; #(
  parameter int unsigned SETS = 256,
  parameter int unsigned WAYS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [ADDR_W-1:0]  source_addr,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count_after,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned ROW_W = WAYS * ENTRY_W;

  // The whole table lives in one memory, one row per set. A row carries the
  // valid mark, the address and the count of every way, so a single read
  // gives everything the lookup needs and a single write stores the outcome.
  // Only one item is in flight, so the write-back of an item always lands
  // before the read of the next one and no forwarding is needed.

  state_t              state;
  state_t              state_next;
  logic                accept;
  opcode_t             op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [SET_W-1:0]    set_q;
  logic [SET_W-1:0]    clr_idx;
  logic                idx_valid;
  logic [SET_W-1:0]    idx;
  logic [ROW_W-1:0]    rd_data;
  entry_t [WAYS-1:0]   rd_row;
  entry_t [WAYS-1:0]   row_next;
  result_t             result;
  logic                lookup_done;
  logic                mem_we;
  logic [SET_W-1:0]    mem_waddr;
  logic [ROW_W-1:0]    mem_wdata;
  logic [COUNT_W-1:0]  max_per_source;
  status_t             out_status;

  assign accept = in_valid && in_ready;

  // Configuration register.
  pscl_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .max_per_source (max_per_source)
  );

  // The set index is the address modulo SETS. For a power of two it is ready
  // at the accept edge, so the row read is issued right there; otherwise the
  // read is issued once the registered reciprocal unit marks the index valid.
  pscl_setidx #(.SETS(SETS)) u_setidx (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .addr      (source_addr),
    .idx_valid (idx_valid),
    .idx       (idx)
  );

  pscl_table #(.SETS(SETS), .ROW_W(ROW_W)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (idx_valid),
    .raddr (idx),
    .rdata (rd_data)
  );

  assign rd_row = rd_data;

  pscl_update #(.WAYS(WAYS)) u_update (
    .opcode         (op_q),
    .source_addr    (addr_q),
    .max_per_source (max_per_source),
    .row            (rd_row),
    .row_next       (row_next),
    .result         (result)
  );

  // The item's payload and the set index are held for the write-back.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode_t'(opcode);
      addr_q <= source_addr;
    end
    if (idx_valid) begin
      set_q <= idx;
    end
  end

  // The lookup finishes only when the output register can take the result,
  // so a result that waits downstream holds the item in the lookup state
  // with the row data still sitting in the memory's read register.
  assign lookup_done = (state == S_LOOKUP) && (!out_valid || out_ready);

  // During the clearing pass the memory is written with all-zero rows, which
  // clears every valid mark; afterwards the write port carries write-backs.
  assign mem_we    = (state == S_CLEAR) || lookup_done;
  assign mem_waddr = (state == S_CLEAR) ? clr_idx : set_q;
  assign mem_wdata = (state == S_CLEAR) ? '0 : ROW_W'(row_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == S_CLEAR) begin
      clr_idx <= clr_idx + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == SET_W'(SETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = idx_valid ? S_LOOKUP : S_INDEX;
        end
      end
      S_INDEX: begin
        if (idx_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Output register: separates the result from the next item's lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lookup_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_done) begin
      out_status  <= result.status;
      count_after <= result.count_after;
    end
  end

  assign status = out_status;

endmodule

`default_nettype wire

### rtl/core/pscl_checker.sv
// ---------------------------------------------------------------------------
// pscl_checker
// Port-level assertions for the connection limiter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pscl_checker import pscl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [COUNT_W-1:0] count_after,
  input logic               pready
);

  // A result held back by the consumer stays put.
  `PSCL_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count_after), "result changed while stalled")

  // Reset starts the clearing pass: no item taken and no result shown.
  `PSCL_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !in_ready && !out_valid, "block ready right after reset")

  // Only one item is worked on at a time.
  `PSCL_ASSERT(a_one_item, clk, rst, in_valid && in_ready |=> !in_ready, "second item taken back to back")

  // Refusals for a full set or an unknown address carry a zero count.
  `PSCL_ASSERT(a_zero_count, clk, rst, out_valid && (status == ST_NO_FREE || status == ST_NOT_FOUND) |-> count_after == '0, "nonzero count on a miss")

  `PSCL_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")

endmodule

bind per_source_connection_limiter pscl_checker u_pscl_checker (.*);

`default_nettype wire
